FILE: design/fcm_pkg.sv
// fcm_pkg: shared types, codes and sizes for the block link table manager
// no dependencies; imported by fat_chain_manager
`timescale 1ns / 1ps

package fcm_pkg;

	localparam int NUM_BLOCKS  = 1024;
	localparam int BLOCK_BYTES = 1024;
	localparam int BLK_W       = $clog2(NUM_BLOCKS);
	localparam int OFF_W       = $clog2(BLOCK_BYTES);
	localparam int LINK_W      = 16;
	localparam int LEN_W       = 20;
	localparam int CNT_W       = 11;

	localparam logic [LINK_W-1:0] LINK_FREE = 16'h0000;
	localparam logic [LINK_W-1:0] LINK_END  = 16'hFFFF;

	localparam logic [BLK_W-1:0] FDB_RESET = 10'd5;

	// request codes
	localparam logic [2:0] REQ_FORMAT   = 3'd0;
	localparam logic [2:0] REQ_ALLOCATE = 3'd1;
	localparam logic [2:0] REQ_NEXT     = 3'd2;
	localparam logic [2:0] REQ_LOCATE   = 3'd3;
	localparam logic [2:0] REQ_FREE     = 3'd4;
	localparam logic [2:0] REQ_TRUNCATE = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_FREE = 2'd1;
	localparam logic [1:0] ST_BAD     = 2'd2;

	typedef struct packed {
		logic [2:0]       req_type;
		logic [BLK_W-1:0] block;
		logic [LEN_W-1:0] byte_length;
	} fcm_in_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [BLK_W-1:0] block_out;
		logic             is_end;
		logic [OFF_W-1:0] block_offset;
		logic [CNT_W-1:0] freed_count;
	} fcm_out_t;

	function automatic logic is_link(input logic [LINK_W-1:0] e);
		return (e != LINK_FREE) && (e != LINK_END) && (e < LINK_W'(NUM_BLOCKS));
	endfunction

endpackage

FILE: design/fat_chain_manager.sv
// fat_chain_manager: block link table with format, allocate, next/extend,
// locate, free-chain and truncate requests; depends on fcm_pkg
`timescale 1ns / 1ps

// Usage
// Requests come in on req_valid/req_stall/req_data, one at a time: req_stall is
// high from the transfer of a request until its result has been handed to the
// output register. Results leave on rsp_valid/rsp_stall/rsp_data, one per request.
// cfg_we/cfg_wdata write first_data_block; write it only while the block is idle.
// Every step goes through the single read and single write port of the link table,
// one table entry per cycle, so the work of a request follows the entries touched:
//   format: every entry of the table
//   allocate: the entries from the first data block to the free block found
//   next_or_extend: the link and the entry it points to, or the scan and link write when it appends
//   locate: the links walked
//   free_chain: the blocks freed
//   truncate: the root entry and the blocks freed
// A request is taken again while a finished result still waits in the output
// register; a finished result waits inside until that register is free.
// Reset empties the output register, sets first_data_block to 5 and leaves the
// table contents unknown until a format request has run.
module fat_chain_manager
	import fcm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [BLK_W-1:0] cfg_wdata,
	input  logic             req_valid,
	output logic             req_stall,
	input  fcm_in_t          req_data,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output fcm_out_t         rsp_data
);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_FORMAT = 10'b0000000010,
		S_SCAN   = 10'b0000000100,
		S_WALK   = 10'b0000001000,
		S_FWALK  = 10'b0000010000,
		S_TRUNC  = 10'b0000100000,
		S_NEXT   = 10'b0001000000,
		S_LOOK   = 10'b0010000000,
		S_LINKW  = 10'b0100000000,
		S_DONE   = 10'b1000000000
	} state_t;

	state_t           state_q, state_d;
	logic [BLK_W-1:0] fdb_q;
	logic [BLK_W-1:0] ds;
	logic [BLK_W-1:0] idx_q, idx_d;
	logic [BLK_W:0]   scan_q, scan_d;
	logic             pend_q, pend_d;
	logic [BLK_W-1:0] pend_a_q, pend_a_d;
	logic             ext_q, ext_d;
	logic [BLK_W-1:0] cur_q, cur_d;
	logic [BLK_W-1:0] blk_q, blk_d;
	logic [BLK_W-1:0] cnt_q, cnt_d;
	logic [OFF_W-1:0] off_q, off_d;
	logic [CNT_W-1:0] freed_q, freed_d, freed_n;
	fcm_out_t         res_q, res_d;
	fcm_out_t         out_q;
	logic             out_valid_q;
	logic             out_free;
	logic             scan_issue;

	// link table, one read and one write port, registered read
	logic [LINK_W-1:0] mem [NUM_BLOCKS];
	logic [LINK_W-1:0] mem_q;
	logic [LINK_W-1:0] byp_d_q;
	logic              byp_q;
	logic [LINK_W-1:0] rd_data;
	logic [BLK_W-1:0]  rd_addr;
	logic              we;
	logic [BLK_W-1:0]  wa;
	logic [LINK_W-1:0] wd;
	logic [LINK_W-1:0] e;

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		mem_q <= mem[rd_addr];
	end

	// same-cycle write to the read address is forwarded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q   <= 1'b0;
			byp_d_q <= LINK_FREE;
		end else begin
			byp_q   <= we && (wa == rd_addr);
			byp_d_q <= wd;
		end
	end

	assign rd_data = byp_q ? byp_d_q : mem_q;
	assign e = rd_data;

	assign ds = (fdb_q == '0) ? BLK_W'(1) : fdb_q;
	assign out_free = !out_valid_q || !rsp_stall;
	assign scan_issue = !scan_q[BLK_W];
	assign freed_n = freed_q + CNT_W'(1);

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp_data = out_q;

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		scan_d   = scan_q;
		pend_d   = pend_q;
		pend_a_d = pend_a_q;
		ext_d    = ext_q;
		cur_d    = cur_q;
		blk_d    = blk_q;
		cnt_d    = cnt_q;
		off_d    = off_q;
		freed_d  = freed_q;
		res_d    = res_q;
		rd_addr  = cur_q;
		we       = 1'b0;
		wa       = cur_q;
		wd       = LINK_FREE;

		unique case (state_q)
			S_IDLE: begin
				rd_addr = req_data.block;
				if (req_valid) begin
					res_d    = '0;
					freed_d  = '0;
					blk_d    = req_data.block;
					cur_d    = req_data.block;
					cnt_d    = BLK_W'(req_data.byte_length >> OFF_W);
					off_d    = req_data.byte_length[OFF_W-1:0];
					idx_d    = '0;
					scan_d   = {1'b0, ds};
					pend_d   = 1'b0;
					ext_d    = 1'b0;
					unique case (req_data.req_type)
						REQ_FORMAT:   state_d = S_FORMAT;
						REQ_ALLOCATE: state_d = S_SCAN;
						REQ_NEXT:     state_d = S_NEXT;
						REQ_LOCATE:   state_d = S_WALK;
						REQ_FREE:     state_d = S_FWALK;
						REQ_TRUNCATE: state_d = S_TRUNC;
						default: begin
							res_d.status = ST_BAD;
							state_d      = S_DONE;
						end
					endcase
				end
			end
			S_FORMAT: begin
				we    = 1'b1;
				wa    = idx_q;
				wd    = (idx_q <= ds) ? LINK_END : LINK_FREE;
				idx_d = idx_q + BLK_W'(1);
				if (idx_q == BLK_W'(NUM_BLOCKS - 1))
					state_d = S_DONE;
			end
			S_SCAN: begin
				// issue one address a cycle, check the one issued before
				rd_addr  = scan_q[BLK_W-1:0];
				pend_d   = scan_issue;
				pend_a_d = scan_q[BLK_W-1:0];
				if (scan_issue)
					scan_d = scan_q + (BLK_W+1)'(1);
				if (pend_q && (e == LINK_FREE)) begin
					we    = 1'b1;
					wa    = pend_a_q;
					wd    = LINK_END;
					cur_d = pend_a_q;
					if (ext_q) begin
						state_d = S_LINKW;
					end else begin
						res_d.block_out = pend_a_q;
						res_d.is_end    = 1'b1;
						state_d         = S_DONE;
					end
				end else if (!scan_issue && !pend_q) begin
					res_d.status = ST_NO_FREE;
					state_d      = S_DONE;
				end
			end
			S_NEXT: begin
				rd_addr = e[BLK_W-1:0];
				priority if (e == LINK_FREE) begin
					res_d.status = ST_BAD;
					state_d      = S_DONE;
				end else if (e == LINK_END) begin
					ext_d   = 1'b1;
					state_d = S_SCAN;
				end else if (is_link(e)) begin
					cur_d   = e[BLK_W-1:0];
					state_d = S_LOOK;
				end else begin
					res_d.status = ST_BAD;
					state_d      = S_DONE;
				end
			end
			S_LOOK: begin
				res_d.block_out = cur_q;
				res_d.is_end    = (e == LINK_END);
				state_d         = S_DONE;
			end
			S_LINKW: begin
				we              = 1'b1;
				wa              = blk_q;
				wd              = LINK_W'(cur_q);
				res_d.block_out = cur_q;
				res_d.is_end    = 1'b1;
				state_d         = S_DONE;
			end
			S_WALK: begin
				rd_addr = e[BLK_W-1:0];
				priority if (cnt_q == '0) begin
					res_d.block_out    = cur_q;
					res_d.is_end       = (e == LINK_END);
					res_d.block_offset = off_q;
					state_d            = S_DONE;
				end else if (!is_link(e)) begin
					res_d.status = ST_BAD;
					state_d      = S_DONE;
				end else begin
					cur_d = e[BLK_W-1:0];
					cnt_d = cnt_q - BLK_W'(1);
				end
			end
			S_FWALK: begin
				rd_addr = e[BLK_W-1:0];
				if (e == LINK_FREE) begin
					res_d.status      = ST_BAD;
					res_d.freed_count = freed_q;
					state_d           = S_DONE;
				end else begin
					we      = 1'b1;
					wa      = cur_q;
					wd      = LINK_FREE;
					freed_d = freed_n;
					priority if (e == LINK_END) begin
						res_d.freed_count = freed_n;
						state_d           = S_DONE;
					end else if (!is_link(e)) begin
						res_d.status      = ST_BAD;
						res_d.freed_count = freed_n;
						state_d           = S_DONE;
					end else begin
						cur_d = e[BLK_W-1:0];
					end
				end
			end
			S_TRUNC: begin
				rd_addr = e[BLK_W-1:0];
				if (e == LINK_FREE) begin
					res_d.status = ST_BAD;
					state_d      = S_DONE;
				end else begin
					we = 1'b1;
					wa = blk_q;
					wd = LINK_END;
					priority if (e == LINK_END) begin
						state_d = S_DONE;
					end else if (!is_link(e)) begin
						res_d.status = ST_BAD;
						state_d      = S_DONE;
					end else begin
						cur_d   = e[BLK_W-1:0];
						state_d = S_FWALK;
					end
				end
			end
			S_DONE: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fdb_q       <= FDB_RESET;
			idx_q       <= '0;
			scan_q      <= '0;
			pend_q      <= 1'b0;
			pend_a_q    <= '0;
			ext_q       <= 1'b0;
			cur_q       <= '0;
			blk_q       <= '0;
			cnt_q       <= '0;
			off_q       <= '0;
			freed_q     <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			idx_q    <= idx_d;
			scan_q   <= scan_d;
			pend_q   <= pend_d;
			pend_a_q <= pend_a_d;
			ext_q    <= ext_d;
			cur_q    <= cur_d;
			blk_q    <= blk_d;
			cnt_q    <= cnt_d;
			off_q    <= off_d;
			freed_q  <= freed_d;
			res_q    <= res_d;
			if (cfg_we)
				fdb_q <= cfg_wdata;
			// output register: load a finished result, drop on transfer
			if ((state_q == S_DONE) && out_free) begin
				out_q       <= res_q;
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: dv/fcm_checker.sv
// fcm_checker: watches the config, request and response channels of fat_chain_manager,
// keeps its own copy of the link table and compares every result field by field
// depends on fcm_pkg
`timescale 1ns / 1ps

module fcm_checker
	import fcm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [BLK_W-1:0] cfg_wdata,
	input  logic             req_valid,
	input  logic             req_stall,
	input  fcm_in_t          req_data,
	input  logic             rsp_valid,
	input  logic             rsp_stall,
	input  fcm_out_t         rsp_data,
	output int               fail_count,
	output int               open_count
);

	logic [LINK_W-1:0] link_mem [NUM_BLOCKS];
	logic [BLK_W-1:0]  fdb_copy;
	fcm_out_t          pending_results [$];
	int                rsp_seen;

	task automatic report(input string msg);
		$display("ERROR %0t ns: %s", $time, msg);
		fail_count++;
	endtask

	// a first data block of zero behaves as one so block 0 is never handed out
	function automatic int base_block();
		return (fdb_copy == '0) ? 1 : int'(fdb_copy);
	endfunction

	function automatic bit points_on(input logic [LINK_W-1:0] e);
		return (e != LINK_FREE) && (e != LINK_END) && (int'(e) < NUM_BLOCKS);
	endfunction

	function automatic bit grab_free(output int got);
		got = 0;
		for (int i = base_block(); i < NUM_BLOCKS; i++) begin
			if (link_mem[i] == LINK_FREE) begin
				link_mem[i] = LINK_END;
				got = i;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// frees up to and including the end marker; a broken link stops it
	function automatic logic [1:0] drop_chain(input int start, inout int cnt);
		int cur;
		logic [LINK_W-1:0] e;
		cur = start;
		for (int n = 0; n < NUM_BLOCKS; n++) begin
			if (cur >= NUM_BLOCKS)
				return ST_BAD;
			e = link_mem[cur];
			if (e == LINK_FREE)
				return ST_BAD;
			link_mem[cur] = LINK_FREE;
			cnt++;
			if (e == LINK_END)
				return ST_OK;
			cur = int'(e);
		end
		return ST_BAD;
	endfunction

	function automatic fcm_out_t table_response(input fcm_in_t q);
		fcm_out_t r;
		int blk, got, hops, cur, cnt;
		logic [LINK_W-1:0] e;
		r = '0;
		blk = int'(q.block);
		cnt = 0;
		case (q.req_type)
			REQ_FORMAT: begin
				for (int i = 0; i < NUM_BLOCKS; i++)
					link_mem[i] = (i <= base_block()) ? LINK_END : LINK_FREE;
			end
			REQ_ALLOCATE: begin
				if (grab_free(got)) begin
					r.block_out = BLK_W'(got);
					r.is_end = 1'b1;
				end else
					r.status = ST_NO_FREE;
			end
			REQ_NEXT: begin
				e = link_mem[blk];
				if (e == LINK_FREE)
					r.status = ST_BAD;
				else if (e == LINK_END) begin
					if (grab_free(got)) begin
						link_mem[blk] = LINK_W'(got);
						r.block_out = BLK_W'(got);
						r.is_end = 1'b1;
					end else
						r.status = ST_NO_FREE;
				end else if (points_on(e)) begin
					r.block_out = BLK_W'(e);
					r.is_end = (link_mem[int'(e)] == LINK_END);
				end else
					r.status = ST_BAD;
			end
			REQ_LOCATE: begin
				hops = int'(q.byte_length) / BLOCK_BYTES;
				cur = blk;
				if (hops >= NUM_BLOCKS)
					r.status = ST_BAD;
				else begin
					// zero hops never checks whether the start entry is free or broken; only is_end reads it
					for (int i = 0; i < hops; i++) begin
						e = link_mem[cur];
						if (!points_on(e)) begin
							r.status = ST_BAD;
							break;
						end
						cur = int'(e);
					end
					if (r.status == ST_OK) begin
						r.block_out = BLK_W'(cur);
						r.is_end = (link_mem[cur] == LINK_END);
						r.block_offset = OFF_W'(int'(q.byte_length) % BLOCK_BYTES);
					end
				end
			end
			REQ_FREE: begin
				if (link_mem[blk] == LINK_FREE)
					r.status = ST_BAD;
				else
					r.status = drop_chain(blk, cnt);
			end
			REQ_TRUNCATE: begin
				if (link_mem[blk] == LINK_FREE)
					r.status = ST_BAD;
				else begin
					e = link_mem[blk];
					link_mem[blk] = LINK_END;
					if (e != LINK_END)
						r.status = drop_chain(int'(e), cnt);
				end
			end
			default: r.status = ST_BAD;
		endcase
		r.freed_count = CNT_W'(cnt);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fcm_out_t want;
		if (!arst_n) begin
			fdb_copy = FDB_RESET;
			pending_results.delete();
			open_count = 0;
			rsp_seen = 0;
			for (int i = 0; i < NUM_BLOCKS; i++)
				link_mem[i] = LINK_FREE;
		end else begin
			if (cfg_we)
				fdb_copy = cfg_wdata;
			if (rsp_valid && !rsp_stall) begin
				rsp_seen++;
				if (pending_results.size() == 0)
					report($sformatf("result %0d arrived with no request open", rsp_seen));
				else begin
					want = pending_results.pop_front();
					if (rsp_data.status !== want.status)
						report($sformatf("result %0d status got %0d want %0d",
							rsp_seen, rsp_data.status, want.status));
					if (rsp_data.block_out !== want.block_out)
						report($sformatf("result %0d block_out got %0d want %0d",
							rsp_seen, rsp_data.block_out, want.block_out));
					if (rsp_data.is_end !== want.is_end)
						report($sformatf("result %0d is_end got %0d want %0d",
							rsp_seen, rsp_data.is_end, want.is_end));
					if (rsp_data.block_offset !== want.block_offset)
						report($sformatf("result %0d block_offset got %0d want %0d",
							rsp_seen, rsp_data.block_offset, want.block_offset));
					if (rsp_data.freed_count !== want.freed_count)
						report($sformatf("result %0d freed_count got %0d want %0d",
							rsp_seen, rsp_data.freed_count, want.freed_count));
				end
			end
			if (req_valid && !req_stall)
				pending_results.push_back(table_response(req_data));
			open_count = pending_results.size();
		end
	end

endmodule

FILE: dv/testbench.sv
// testbench: drives fat_chain_manager with directed and random requests under random
// sender gaps and receiver stalls; depends on fcm_pkg, fcm_checker and the design
`timescale 1ns / 1ps

module testbench;
	import fcm_pkg::*;

	// request codes the block does not know
	localparam logic [2:0] REQ_SPARE_6 = 3'd6;
	localparam logic [2:0] REQ_SPARE_7 = 3'd7;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [BLK_W-1:0] cfg_wdata;
	logic             req_valid;
	logic             req_stall;
	fcm_in_t          req_data;
	logic             rsp_valid;
	logic             rsp_stall;
	fcm_out_t         rsp_data;
	int               fail_count;
	int               open_count;

	logic [BLK_W-1:0] fdb_now;
	bit               tx_quiet;
	int               rx_hold;
	int               rx_seen;
	int               fdb_plan [8] = '{1, 0, 1023, -1, 1023, 2, -1, 5};
	bit               fmt_plan [8] = '{1, 1, 0, 1, 1, 1, 0, 1};

	fat_chain_manager uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	fcm_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_data   (req_data),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_data   (rsp_data),
		.fail_count (fail_count),
		.open_count (open_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#25_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// receiver: holds off each result for a random number of valid cycles
	initial begin
		rsp_stall = 1'b0;
		rx_hold = 0;
		rx_seen = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				rx_seen++;
				rx_hold = (rx_seen % 100 < 25) ? 0 : $urandom_range(0, 19);
			end
			@(negedge clk);
			if (rx_hold > 0) begin
				rsp_stall <= 1'b1;
				if (rsp_valid)
					rx_hold--;
			end else
				rsp_stall <= 1'b0;
		end
	end

	function automatic fcm_in_t req_of(input logic [2:0] rt, input int blk, input int len);
		fcm_in_t q;
		q.req_type = rt;
		q.block = BLK_W'(blk);
		q.byte_length = LEN_W'(len);
		return q;
	endfunction

	// mostly near the data start, where the chains live
	function automatic logic [BLK_W-1:0] pick_block();
		int lo, hi;
		lo = (fdb_now == '0) ? 1 : int'(fdb_now);
		hi = (lo + 40 > NUM_BLOCKS - 1) ? NUM_BLOCKS - 1 : lo + 40;
		lo = (lo > 2) ? lo - 2 : 0;
		if ($urandom_range(0, 9) < 8)
			return BLK_W'($urandom_range(lo, hi));
		return BLK_W'($urandom_range(0, NUM_BLOCKS - 1));
	endfunction

	function automatic fcm_in_t random_request();
		fcm_in_t q;
		int pick;
		q.req_type = REQ_ALLOCATE;
		q.block = pick_block();
		q.byte_length = LEN_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 2)
			q.req_type = REQ_FORMAT;
		else if (pick < 20)
			q.req_type = REQ_ALLOCATE;
		else if (pick < 45)
			q.req_type = REQ_NEXT;
		else if (pick < 65) begin
			q.req_type = REQ_LOCATE;
			if ($urandom_range(0, 6) != 0)
				q.byte_length = LEN_W'($urandom_range(0, 5) * BLOCK_BYTES
					+ $urandom_range(0, BLOCK_BYTES - 1));
		end else if (pick < 77)
			q.req_type = REQ_FREE;
		else if (pick < 89)
			q.req_type = REQ_TRUNCATE;
		else if (pick < 96) begin
			q.req_type = 3'($urandom_range(REQ_FORMAT, REQ_SPARE_7));
			q.block = BLK_W'($urandom);
		end else
			q.req_type = pick[0] ? REQ_SPARE_7 : REQ_SPARE_6;
		return q;
	endfunction

	task automatic push_req(input fcm_in_t q);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 19);
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req_data <= q;
		do
			@(posedge clk);
		while (req_stall !== 1'b0);
	endtask

	// drop valid and wait until every open request has its result
	task automatic wait_idle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (open_count != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_fdb(input logic [BLK_W-1:0] v);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		fdb_now = v;
	endtask

	initial begin
		int b;
		int v;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_valid = 1'b0;
		req_data = '0;
		tx_quiet = 1'b0;
		fdb_now = FDB_RESET;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		write_fdb(FDB_RESET);
		b = int'(FDB_RESET);
		push_req(req_of(REQ_FORMAT, 0, 0));
		push_req(req_of(REQ_ALLOCATE, 0, 0));
		push_req(req_of(REQ_NEXT, b, 0));
		push_req(req_of(REQ_NEXT, b, 0));
		push_req(req_of(REQ_NEXT, b + 2, 0));
		push_req(req_of(REQ_LOCATE, b, 0));
		push_req(req_of(REQ_LOCATE, b, 3 * BLOCK_BYTES - 1));
		push_req(req_of(REQ_LOCATE, b, (1 << LEN_W) - 1));
		push_req(req_of(REQ_LOCATE, NUM_BLOCKS - 1, 0));
		// chain requests on a free block
		push_req(req_of(REQ_NEXT, 900, 0));
		push_req(req_of(REQ_FREE, 900, 0));
		push_req(req_of(REQ_TRUNCATE, 900, 0));
		// leave the root pointing at a freed block, then walk and free across it
		push_req(req_of(REQ_FREE, b + 2, 0));
		push_req(req_of(REQ_LOCATE, b, BLOCK_BYTES));
		push_req(req_of(REQ_NEXT, b, 0));
		push_req(req_of(REQ_FREE, b, 0));
		push_req(req_of(REQ_ALLOCATE, 0, 0));
		push_req(req_of(REQ_NEXT, b, 0));
		push_req(req_of(REQ_NEXT, b + 2, 0));
		push_req(req_of(REQ_TRUNCATE, b, 0));
		push_req(req_of(REQ_TRUNCATE, b + 1, 0));
		push_req(req_of(REQ_FREE, 0, 0));
		push_req(req_of(REQ_SPARE_6, NUM_BLOCKS - 1, (1 << LEN_W) - 1));
		push_req(req_of(REQ_SPARE_7, 0, 0));

		foreach (fdb_plan[p]) begin
			v = (fdb_plan[p] < 0) ? $urandom_range(1, NUM_BLOCKS - 2) : fdb_plan[p];
			write_fdb(BLK_W'(v));
			if (fmt_plan[p])
				push_req(req_of(REQ_FORMAT, $urandom, $urandom));
			for (int k = 0; k < 120; k++) begin
				if (k == 60)
					wait_idle();
				tx_quiet = (k >= 30 && k < 60);
				push_req(random_request());
			end
			tx_quiet = 1'b0;
		end

		wait_idle();
		repeat (64) @(negedge clk);
		if (fail_count == 0 && open_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
